[src/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every edge outside reset
`define APC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define APC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/apc_pkg.sv]
`default_nettype none
package apc_pkg;

  localparam int NUMBER_WIDTH = 31;
  localparam int SUM_WIDTH    = 34;
  // proper divisor sum stays below 8 times the number
  localparam int ACC_WIDTH    = (NUMBER_WIDTH + 3 > SUM_WIDTH) ? NUMBER_WIDTH + 3 : SUM_WIDTH;
  localparam int CNT_WIDTH    = $clog2(NUMBER_WIDTH);

  typedef struct packed {
    logic [NUMBER_WIDTH-1:0] first_number;
    logic [NUMBER_WIDTH-1:0] second_number;
  } apc_in_t;

  typedef struct packed {
    logic                 pair_is_amicable;
    logic [SUM_WIDTH-1:0] first_divisor_sum;
    logic [SUM_WIDTH-1:0] second_divisor_sum;
  } apc_out_t;

  typedef struct packed {
    logic                    done;
    logic [NUMBER_WIDTH-1:0] quo;
    logic [NUMBER_WIDTH-1:0] rem;
  } apc_div_res_t;

  typedef struct packed {
    logic                 done;
    logic [ACC_WIDTH-1:0] sum;
  } apc_dsum_res_t;

endpackage
`default_nettype wire

[src/apc_div.sv]
`default_nettype none
module apc_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [apc_pkg::NUMBER_WIDTH-1:0] dividend,
  input  wire logic [apc_pkg::NUMBER_WIDTH-1:0] divisor,
  output apc_pkg::apc_div_res_t                 res
);

  localparam int W  = apc_pkg::NUMBER_WIDTH;
  localparam int CW = apc_pkg::CNT_WIDTH;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          ge;

  // one restoring step per cycle, quotient bits shift in behind the dividend
  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = ~diff[W];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W - 1);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[W-1:0] : shifted[W-1:0];
      quo_nxt = {quo_r[W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;
  assign res.rem  = rem_r;

endmodule
`default_nettype wire

[src/apc_dsum.sv]
`default_nettype none
module apc_dsum (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [apc_pkg::NUMBER_WIDTH-1:0] number,
  output apc_pkg::apc_dsum_res_t                res
);

  localparam int W  = apc_pkg::NUMBER_WIDTH;
  localparam int AW = apc_pkg::ACC_WIDTH;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]    st_r, st_nxt;
  logic [W-1:0]  n_r, n_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [AW-1:0] acc_r, acc_nxt;
  logic          div_start;
  logic [W-1:0]  div_n;
  logic [W-1:0]  div_d;
  logic [W-1:0]  q_add;
  apc_pkg::apc_div_res_t div_res;

  apc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .res      (div_res)
  );

  // square root divisor counts once
  assign q_add = (div_res.quo != d_r) ? div_res.quo : '0;

  always_comb begin
    st_nxt    = st_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    acc_nxt   = acc_r;
    div_start = 1'b0;
    div_n     = n_r;
    div_d     = d_r;
    case (st_r)
      S_IDLE, S_FIN: begin
        if (st_r == S_FIN) st_nxt = S_IDLE;
        if (start) begin
          n_nxt = number;
          if (number < W'(2)) begin
            acc_nxt = '0;
            st_nxt  = S_FIN;
          end else begin
            acc_nxt   = AW'(1);
            d_nxt     = W'(2);
            div_start = 1'b1;
            div_n     = number;
            div_d     = W'(2);
            st_nxt    = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          if (d_r > div_res.quo) begin
            st_nxt = S_FIN;
          end else begin
            if (div_res.rem == '0) acc_nxt = acc_r + AW'(d_r) + AW'(q_add);
            d_nxt     = d_r + 1'b1;
            div_start = 1'b1;
            div_d     = d_r + 1'b1;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    acc_r <= acc_nxt;
  end

  assign res.done = (st_r == S_FIN);
  assign res.sum  = acc_r;

endmodule
`default_nettype wire

[src/amicable_pair_check.sv]
// Amicable pair check: takes two numbers on the in_ channel and returns, on the
// out_ channel, the sum of proper divisors of each and a flag that is set when
// each sum equals the other number. The numbers are handled one after the other
// by trial division with a single shared restoring divider that loads its
// operands and then produces one quotient bit per cycle, so each candidate
// divisor costs one division; candidates run from 2 up to the square root of
// the number, and a number below 2 gets a sum of 0 without any division. The
// result beat appears in the same cycle that the input is released. The input
// is stalled for the whole computation. A finished result sits in the output
// register until taken and the next beat may be accepted meanwhile; if that one
// finishes while the earlier result is still held, it waits in the divisor-sum
// unit and the input stays stalled until the output register frees.
`default_nettype none
`include "assert_macros.svh"
module amicable_pair_check (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire apc_pkg::apc_in_t in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output apc_pkg::apc_out_t out_data
);

  localparam int W  = apc_pkg::NUMBER_WIDTH;
  localparam int AW = apc_pkg::ACC_WIDTH;
  localparam int SW = apc_pkg::SUM_WIDTH;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN_A = 2'd1;
  localparam logic [1:0] ST_RUN_B = 2'd2;
  localparam logic [1:0] ST_WAIT  = 2'd3;

  logic [1:0]        st_r, st_nxt;
  apc_pkg::apc_in_t  in_q_r, in_q_nxt;
  logic [AW-1:0]     sa_r, sa_nxt;
  apc_pkg::apc_out_t out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              in_accept;
  logic              out_free;
  logic              res_write;
  logic              ds_start;
  logic [W-1:0]      ds_n;
  apc_pkg::apc_dsum_res_t ds_res;

  assign in_stall  = (st_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !(out_valid_r && out_stall);
  // second sum stays in the divisor-sum unit while a held result blocks the register
  assign res_write = out_free && (((st_r == ST_RUN_B) && ds_res.done) || (st_r == ST_WAIT));

  assign ds_start = in_accept || ((st_r == ST_RUN_A) && ds_res.done);
  assign ds_n     = in_accept ? in_data.first_number : in_q_r.second_number;

  apc_dsum u_dsum (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ds_start),
    .number (ds_n),
    .res    (ds_res)
  );

  always_comb begin
    st_nxt        = st_r;
    in_q_nxt      = in_q_r;
    sa_nxt        = sa_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (st_r)
      ST_IDLE: begin
        if (in_accept) begin
          in_q_nxt = in_data;
          st_nxt   = ST_RUN_A;
        end
      end
      ST_RUN_A: begin
        if (ds_res.done) begin
          sa_nxt = ds_res.sum;
          st_nxt = ST_RUN_B;
        end
      end
      ST_RUN_B: begin
        if (ds_res.done) st_nxt = out_free ? ST_IDLE : ST_WAIT;
      end
      ST_WAIT: begin
        if (out_free) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (res_write) begin
      // flag compares the full sums, before they are cut to the beat width
      out_nxt.pair_is_amicable   = (sa_r == AW'(in_q_r.second_number)) &&
                                   (ds_res.sum == AW'(in_q_r.first_number));
      out_nxt.first_divisor_sum  = sa_r[SW-1:0];
      out_nxt.second_divisor_sum = ds_res.sum[SW-1:0];
      out_valid_nxt              = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_q_r <= in_q_nxt;
    sa_r   <= sa_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `APC_ASSERT_NEXT(a_out_held, out_valid_r && out_stall, out_valid_r && $stable(out_r), "stalled result beat changed")
  `APC_ASSERT(a_no_done_when_idle, (st_r != ST_IDLE) || !ds_res.done, "divisor sum finished while idle")
  `APC_ASSERT_NEXT(a_accept_starts, in_accept, st_r == ST_RUN_A, "accepted beat did not start work")
  `APC_ASSERT_NEXT(a_finish_shows, (st_r == ST_RUN_B) && ds_res.done, out_valid_r, "finished result not shown")

endmodule
`default_nettype wire

[test/testbench.sv]
`default_nettype none
module testbench;

  localparam int NW = apc_pkg::NUMBER_WIDTH;
  localparam int SW = apc_pkg::SUM_WIDTH;
  localparam int unsigned IDLE_LIMIT = 12_000_000;
  localparam int unsigned LONG_HOLD  = 50_000;
  localparam int unsigned RANDOM_ITEMS = 80;
  localparam longint unsigned MAX_NUMBER = (64'd1 << NW) - 1;

  typedef struct {
    apc_pkg::apc_in_t  pair;
    bit                known;
    apc_pkg::apc_out_t result;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  apc_pkg::apc_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  apc_pkg::apc_out_t out_data;

  apc_pkg::apc_out_t pending_sums[$];
  stim_row_t   directed_rows[$];
  int unsigned errors = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  bit          long_hold_req = 1'b0;

  int unsigned amicable_lo [10] = '{220, 1184, 2620, 5020, 6232, 10744, 12285, 17296,
                                   63020, 66928};
  int unsigned amicable_hi [10] = '{284, 1210, 2924, 5564, 6368, 10856, 14595, 18416,
                                   76084, 66992};
  int unsigned perfect_nums [4] = '{6, 28, 496, 8128};

  amicable_pair_check DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // sum of proper divisors, pairing each divisor with its cofactor
  function automatic longint unsigned divisor_total(longint unsigned n);
    longint unsigned acc;
    longint unsigned d;
    if (n < 2) return 0;
    acc = 1;
    for (d = 2; d <= n / d; d++) begin
      if (n % d == 0) begin
        acc += d;
        if (n / d != d) acc += n / d;
      end
    end
    return acc;
  endfunction

  function automatic apc_pkg::apc_out_t pair_verdict(apc_pkg::apc_in_t item);
    longint unsigned a;
    longint unsigned b;
    longint unsigned sa;
    longint unsigned sb;
    apc_pkg::apc_out_t r;
    a  = 64'(item.first_number);
    b  = 64'(item.second_number);
    sa = divisor_total(a);
    sb = divisor_total(b);
    r.pair_is_amicable   = (sa == b) && (sb == a);
    r.first_divisor_sum  = sa[SW-1:0];
    r.second_divisor_sum = sb[SW-1:0];
    return r;
  endfunction

  function automatic logic [NW-1:0] random_number(int unsigned max_bits);
    int unsigned w;
    w = $urandom_range(1, max_bits);
    return NW'($urandom & ((32'd1 << w) - 1));
  endfunction

  task automatic add_row(input longint unsigned a, input longint unsigned b, input bit known,
                         input bit flag, input longint unsigned s1, input longint unsigned s2);
    stim_row_t row;
    row.pair.first_number  = a[NW-1:0];
    row.pair.second_number = b[NW-1:0];
    row.known                     = known;
    row.result.pair_is_amicable   = flag;
    row.result.first_divisor_sum  = s1[SW-1:0];
    row.result.second_divisor_sum = s2[SW-1:0];
    directed_rows.push_back(row);
  endtask

  // hold the beat until taken, then record what it should produce
  task automatic offer(input apc_pkg::apc_in_t item, input bit known,
                       input apc_pkg::apc_out_t typed);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_sums.push_back(known ? typed : pair_verdict(item));
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  initial begin
    apc_pkg::apc_in_t item;
    int unsigned kind;
    int unsigned idx;
    logic [NW-1:0] tmp;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;

    add_row(0, 0, 1, 1, 0, 0);
    add_row(1, 1, 1, 0, 0, 0);
    add_row(0, 1, 1, 0, 0, 0);
    add_row(1, 0, 1, 0, 0, 0);
    // largest value is a mersenne prime, so both sums are one
    add_row(MAX_NUMBER, MAX_NUMBER, 1, 0, 1, 1);
    add_row(2, 3, 1, 0, 1, 1);
    add_row(4, 9, 0, 0, 0, 0);
    add_row(6, 6, 1, 1, 6, 6);
    add_row(28, 28, 1, 1, 28, 28);
    add_row(496, 496, 0, 0, 0, 0);
    add_row(8128, 8128, 0, 0, 0, 0);
    add_row(220, 284, 1, 1, 284, 220);
    add_row(284, 220, 1, 1, 220, 284);
    add_row(220, 220, 0, 0, 0, 0);
    add_row(1184, 1210, 0, 0, 0, 0);
    add_row(12285, 14595, 0, 0, 0, 0);
    add_row(66928, 66992, 0, 0, 0, 0);
    add_row(6, 28, 0, 0, 0, 0);
    add_row(12, 16, 0, 0, 0, 0);
    add_row(0, 65535, 0, 0, 0, 0);
    add_row(65536, 1, 0, 0, 0, 0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      offer(directed_rows[i].pair, directed_rows[i].known, directed_rows[i].result);

    // receiver goes quiet while small items keep coming
    long_hold_req = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        item.first_number  = random_number(12);
        item.second_number = random_number(12);
      end else if (kind < 60) begin
        idx = $urandom_range(0, 9);
        item.first_number  = NW'(amicable_lo[idx]);
        item.second_number = NW'(amicable_hi[idx]);
        if ($urandom_range(0, 3) == 0) item.second_number ^= 1;
        if ($urandom_range(0, 1)) begin
          tmp = item.first_number;
          item.first_number  = item.second_number;
          item.second_number = tmp;
        end
      end else if (kind < 70) begin
        idx = $urandom_range(0, 3);
        item.first_number  = NW'(perfect_nums[idx]);
        item.second_number = $urandom_range(0, 1) ? NW'(perfect_nums[idx]) : random_number(13);
      end else if (kind < 80) begin
        item.first_number  = random_number(18);
        item.second_number = random_number(18);
      end else if (kind < 90) begin
        item.first_number  = NW'($urandom_range(0, 3));
        item.second_number = random_number(10);
        if ($urandom_range(0, 1)) begin
          tmp = item.first_number;
          item.first_number  = item.second_number;
          item.second_number = tmp;
        end
      end else begin
        item.first_number  = random_number(14);
        item.second_number = item.first_number;
      end
      offer(item, 1'b0, '0);
      if (n == RANDOM_ITEMS / 2) drain();
    end

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_sums.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // receiver stall pattern, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned run_left;
    int unsigned mode;
    hold_left = 0;
    run_left  = 0;
    mode      = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
        out_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          mode     = $urandom_range(0, 2);
          run_left = $urandom_range(1, 60);
        end
        run_left--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    apc_pkg::apc_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && !out_stall) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected result beat, got %p", $time, out_data);
        errors++;
      end else begin
        want = pending_sums.pop_front();
        if (out_data.pair_is_amicable !== want.pair_is_amicable) begin
          $display("%0t: pair_is_amicable expected %0d got %0d", $time,
                   want.pair_is_amicable, out_data.pair_is_amicable);
          errors++;
        end
        if (out_data.first_divisor_sum !== want.first_divisor_sum) begin
          $display("%0t: first_divisor_sum expected %0d got %0d", $time,
                   want.first_divisor_sum, out_data.first_divisor_sum);
          errors++;
        end
        if (out_data.second_divisor_sum !== want.second_divisor_sum) begin
          $display("%0t: second_divisor_sum expected %0d got %0d", $time,
                   want.second_divisor_sum, out_data.second_divisor_sum);
          errors++;
        end
      end
    end
  end

  // a beat on either side resets the count
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
`default_nettype wire

[amicable_pair_check.f]
+incdir+src
src/apc_pkg.sv
src/apc_div.sv
src/apc_dsum.sv
src/amicable_pair_check.sv
test/testbench.sv
